// ===== src/monomer_energy_contraction_defines.svh =====
// assertion macros for the monomer energy contraction block
// used by mec_ctrl and mec_dpath, relies on clk and rst_n in the including module
`ifndef MONOMER_ENERGY_CONTRACTION_DEFINES_SVH
`define MONOMER_ENERGY_CONTRACTION_DEFINES_SVH

`ifndef SYNTHESIS
`define MEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MEC_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MEC_ASSERT(lbl, prop, msg)
`define MEC_ASSERT_NORST(lbl, prop, msg)
`endif

`endif

// ===== src/mec_pkg.sv =====
// shared types and codes for the monomer energy contraction block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mec_pkg;

  localparam int FRAC_BITS = 24;

  localparam logic [2:0] REQ_LOAD_V  = 3'd0;
  localparam logic [2:0] REQ_LOAD_D  = 3'd1;
  localparam logic [2:0] REQ_LOAD_H  = 3'd2;
  localparam logic [2:0] REQ_LOAD_R  = 3'd3;
  localparam logic [2:0] REQ_COMPUTE = 3'd4;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [15:0]        elem_index;
    logic signed [31:0] elem_value;
  } mec_in_t;

  typedef struct packed {
    logic signed [63:0] energy;
    logic               saturated;
  } mec_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_RUN2,
    ST_RUN1,
    ST_DRAIN
  } mec_state_t;

  typedef struct packed {
    logic cfg_wr;
    logic load;
    logic clear;
    logic step_two;
    logic step_one;
    logic publish;
  } mec_cmd_t;

  typedef struct packed {
    logic last_two;
    logic last_one;
    logic pipe_busy;
    logic out_free;
  } mec_sts_t;

endpackage

`default_nettype wire

// ===== src/mec_ctrl.sv =====
// controller state machine: handshakes, compute walk sequencing, result hand-off
// depends on mec_pkg and monomer_energy_contraction_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "monomer_energy_contraction_defines.svh"

module mec_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       req_type,
  input  wire mec_pkg::mec_sts_t sts,
  output mec_pkg::mec_cmd_t     cmd
);

  mec_pkg::mec_state_t state_r, state_nxt;
  logic                settle_r, settle_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mec_pkg::ST_IDLE;
      settle_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      settle_r <= settle_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    settle_nxt = settle_r;
    cmd        = '0;
    cfg_ready  = 1'b0;
    in_ready   = 1'b0;
    case (state_r)
      mec_pkg::ST_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
          settle_nxt = 1'b0;
          state_nxt  = mec_pkg::ST_SETTLE;
        end else if (in_valid) begin
          if (req_type == mec_pkg::REQ_COMPUTE) begin
            cmd.clear = 1'b1;
            state_nxt = mec_pkg::ST_RUN2;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      mec_pkg::ST_SETTLE: begin
        // orbital extents follow a new count through orb_r, then n2_r, then n4_r
        if (settle_r) begin
          state_nxt = mec_pkg::ST_IDLE;
        end else begin
          settle_nxt = 1'b1;
        end
      end
      mec_pkg::ST_RUN2: begin
        cmd.step_two = 1'b1;
        if (sts.last_two) begin
          state_nxt = mec_pkg::ST_RUN1;
        end
      end
      mec_pkg::ST_RUN1: begin
        cmd.step_one = 1'b1;
        if (sts.last_one) begin
          state_nxt = mec_pkg::ST_DRAIN;
        end
      end
      mec_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy && sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = mec_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mec_pkg::ST_IDLE;
      end
    endcase
  end

  `MEC_ASSERT(a_compute_starts_walk, (in_valid && in_ready && req_type == mec_pkg::REQ_COMPUTE) |=> (state_r == mec_pkg::ST_RUN2), "compute beat did not start the walk")
  `MEC_ASSERT(a_no_beat_while_walking, (state_r == mec_pkg::ST_RUN2 || state_r == mec_pkg::ST_RUN1) |-> (!in_ready && !cfg_ready), "beat taken during compute walk")
  `MEC_ASSERT(a_cfg_then_settle, (cfg_valid && cfg_ready) |=> (state_r == mec_pkg::ST_SETTLE && !in_ready), "config write not followed by settle")

endmodule

`default_nettype wire

// ===== src/mec_dpath.sv =====
// datapath: orbital extents, element stores, index walk, multiply and saturating accumulate
// depends on mec_pkg and monomer_energy_contraction_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "monomer_energy_contraction_defines.svh"

module mec_dpath #(
  parameter int MAX_ORB = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mec_pkg::mec_cmd_t cmd,
  output mec_pkg::mec_sts_t      sts,
  input  wire logic [4:0]        cfg_data,
  input  wire mec_pkg::mec_in_t  in_data,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output mec_pkg::mec_out_t      out_data
);

  localparam int NMAX      = (MAX_ORB > 31) ? 31 : MAX_ORB;
  localparam int TWO_FULL  = MAX_ORB * MAX_ORB * MAX_ORB * MAX_ORB;
  localparam int TWO_DEPTH = (TWO_FULL > 65536) ? 65536 : TWO_FULL;
  localparam int ONE_DEPTH = MAX_ORB * MAX_ORB;
  localparam int TAW       = $clog2(TWO_DEPTH);
  localparam int OAW       = $clog2(ONE_DEPTH);
  localparam int N2W       = $clog2(NMAX * NMAX + 1);
  localparam int N4W       = $clog2(NMAX * NMAX * NMAX * NMAX + 1);

  // orbital count and extents
  logic [4:0]     orb_r;
  logic [4:0]     n_eff;
  logic [4:0]     n_m1;
  logic [N2W-1:0] n2_r, n2_nxt;
  logic [N4W-1:0] n4_r, n4_nxt;

  always_comb begin
    if (orb_r == 5'd0) begin
      n_eff = 5'd1;
    end else if (32'(orb_r) > NMAX) begin
      n_eff = 5'(NMAX);
    end else begin
      n_eff = orb_r;
    end
  end

  assign n_m1   = n_eff - 5'd1;
  assign n2_nxt = N2W'({5'd0, n_eff} * {5'd0, n_eff});
  assign n4_nxt = N4W'(20'(n2_r) * 20'(n2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orb_r <= 5'd1;
      n2_r  <= N2W'(1);
      n4_r  <= N4W'(1);
    end else begin
      if (cmd.cfg_wr) begin
        orb_r <= cfg_data;
      end
      n2_r <= n2_nxt;
      n4_r <= n4_nxt;
    end
  end

  // load decode
  logic fits_two, fits_one;
  logic wr_v, wr_d, wr_h, wr_r;

  assign fits_two = 32'(in_data.elem_index) < 32'(n4_r);
  assign fits_one = 32'(in_data.elem_index) < 32'(n2_r);
  assign wr_v = cmd.load && (in_data.req_type == mec_pkg::REQ_LOAD_V) && fits_two;
  assign wr_d = cmd.load && (in_data.req_type == mec_pkg::REQ_LOAD_D) && fits_two;
  assign wr_h = cmd.load && (in_data.req_type == mec_pkg::REQ_LOAD_H) && fits_one;
  assign wr_r = cmd.load && (in_data.req_type == mec_pkg::REQ_LOAD_R) && fits_one;

  // index walk, density index is pq*n^2 + s*n + r
  logic [N4W-1:0] iv_r;
  logic [N4W-1:0] pq_off_r;
  logic [N2W-1:0] s_off_r;
  logic [4:0]     s_r, r_r;
  logic [N2W-1:0] k_r;
  logic [N4W-1:0] id_c;

  assign id_c = pq_off_r + N4W'(s_off_r) + N4W'(r_r);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      iv_r     <= '0;
      pq_off_r <= '0;
      s_off_r  <= '0;
      s_r      <= '0;
      r_r      <= '0;
      k_r      <= '0;
    end else begin
      if (cmd.step_two) begin
        iv_r <= iv_r + N4W'(1);
        if (s_r == n_m1) begin
          s_r     <= '0;
          s_off_r <= '0;
          if (r_r == n_m1) begin
            r_r      <= '0;
            pq_off_r <= pq_off_r + N4W'(n2_r);
          end else begin
            r_r <= r_r + 5'd1;
          end
        end else begin
          s_r     <= s_r + 5'd1;
          s_off_r <= s_off_r + N2W'(n_eff);
        end
      end
      if (cmd.step_one) begin
        k_r <= k_r + N2W'(1);
      end
    end
  end

  assign sts.last_two = (iv_r == n4_r - N4W'(1));
  assign sts.last_one = (k_r == n2_r - N2W'(1));

  // element stores
  logic [31:0] two_int_mem [TWO_DEPTH];
  logic [31:0] two_den_mem [TWO_DEPTH];
  logic [31:0] one_int_mem [ONE_DEPTH];
  logic [31:0] one_den_mem [ONE_DEPTH];
  logic [31:0] two_int_q_r, two_den_q_r, one_int_q_r, one_den_q_r;

  always_ff @(posedge clk) begin
    if (wr_v) begin
      two_int_mem[in_data.elem_index[TAW-1:0]] <= in_data.elem_value;
    end
    two_int_q_r <= two_int_mem[iv_r[TAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_d) begin
      two_den_mem[in_data.elem_index[TAW-1:0]] <= in_data.elem_value;
    end
    two_den_q_r <= two_den_mem[id_c[TAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_h) begin
      one_int_mem[in_data.elem_index[OAW-1:0]] <= in_data.elem_value;
    end
    one_int_q_r <= one_int_mem[k_r[OAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_r) begin
      one_den_mem[in_data.elem_index[OAW-1:0]] <= in_data.elem_value;
    end
    one_den_q_r <= one_den_mem[k_r[OAW-1:0]];
  end

  // multiply and accumulate pipeline
  logic               s1_vld_r, s1_one_r, s2_vld_r;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod_nxt, prod_r;
  logic signed [63:0] addend, sum, acc_r;
  logic               ovf, sat_r;

  assign op_a     = s1_one_r ? one_int_q_r : two_int_q_r;
  assign op_b     = s1_one_r ? one_den_q_r : two_den_q_r;
  assign prod_nxt = 64'(op_a) * 64'(op_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.step_two || cmd.step_one;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_one_r <= cmd.step_one;
    prod_r   <= prod_nxt;
  end

  assign addend = prod_r >>> mec_pkg::FRAC_BITS;
  assign sum    = acc_r + addend;
  assign ovf    = (acc_r[63] == addend[63]) && (sum[63] != acc_r[63]);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      acc_r <= '0;
      sat_r <= 1'b0;
    end else if (s2_vld_r) begin
      if (ovf) begin
        acc_r <= acc_r[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        sat_r <= 1'b1;
      end else begin
        acc_r <= sum;
      end
    end
  end

  assign sts.pipe_busy = s1_vld_r || s2_vld_r;

  // result register
  logic              out_valid_r;
  mec_pkg::mec_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data_r.energy    <= acc_r;
      out_data_r.saturated <= sat_r;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  `MEC_ASSERT(a_clear_zeroes_acc, cmd.clear |=> (acc_r == 64'sd0 && !sat_r), "accumulator not cleared at compute start")
  `MEC_ASSERT(a_publish_when_free, cmd.publish |-> (!s1_vld_r && !s2_vld_r && (!out_valid_r || out_ready)), "result published while busy or output full")
  `MEC_ASSERT(a_publish_value, cmd.publish |=> (out_valid_r && out_data_r.energy == $past(acc_r)), "published energy differs from accumulator")
  `MEC_ASSERT_NORST(a_reset_drops_result, (!rst_n) |=> !out_valid_r, "result beat survives reset")

endmodule

`default_nettype wire

// ===== src/monomer_energy_contraction.sv =====
// monomer energy contraction: load beats are taken one beat per cycle while idle
// a compute beat walks n^4 + n^2 element pairs through one multiply-accumulate
// pipe, one pair a cycle; its result is published once the pipe drains and the output is free
// a config write holds off input beats while the extents update
// synchronous active-low reset clears control state and sets the orbital count to 1;
// the element stores are not cleared
`timescale 1ns / 1ps
`default_nettype none

module monomer_energy_contraction #(
  parameter int MAX_ORB = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [4:0]        cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mec_pkg::mec_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mec_pkg::mec_out_t      out_data
);

  mec_pkg::mec_cmd_t cmd;
  mec_pkg::mec_sts_t sts;

  mec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (in_data.req_type),
    .sts       (sts),
    .cmd       (cmd)
  );

  mec_dpath #(
    .MAX_ORB (MAX_ORB)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/monomer_energy_contraction_tb.sv =====
// testbench for monomer_energy_contraction: loads the four element stores, runs computes
// and checks each energy beat against a fixed-point contraction kept in the bench
// depends on mec_pkg and the monomer_energy_contraction rtl
`timescale 1ns / 1ps

module monomer_energy_contraction_tb;

  localparam int MAX_ORB         = 16;
  localparam int IDLE_LIMIT      = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 16;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [4:0]        cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  mec_pkg::mec_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  mec_pkg::mec_out_t out_data;

  monomer_energy_contraction #(
    .MAX_ORB(MAX_ORB)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // bench copy of the stores and the orbital count
  int          v_store [MAX_ORB**4];
  int          d_store [MAX_ORB**4];
  int          h_store [MAX_ORB**2];
  int          r_store [MAX_ORB**2];
  int unsigned v_prefix = 0;
  int unsigned d_prefix = 0;
  int unsigned h_prefix = 0;
  int unsigned r_prefix = 0;
  logic [4:0]  orb_reg  = 5'd1;

  mec_pkg::mec_out_t pending_energy [$];
  int                fail_count   = 0;
  int                idle_cycles  = 0;
  int                burst_left   = 0;
  bit                gaps_on      = 1'b1;
  int                hold_req_seq = 0;
  int                hold_seen    = 0;
  int                hold_left    = 0;
  int                ready_run    = 0;
  logic              ready_lvl    = 1'b1;
  mec_pkg::mec_out_t exp_beat;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned orbs_eff();
    if (orb_reg == 5'd0) return 1;
    if (32'(orb_reg) > MAX_ORB) return MAX_ORB;
    return 32'(orb_reg);
  endfunction

  // q8.24 product floored to q.24, added with saturation
  function automatic longint mac_q24(input longint acc, input int a, input int b,
                                     inout logic sat);
    longint prod;
    logic [64:0] sum;
    prod = (longint'(a) * longint'(b)) >>> 24;
    sum  = {acc[63], acc} + {prod[63], prod};
    if (sum[64] != sum[63]) begin
      sat = 1'b1;
      return sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return sum[63:0];
  endfunction

  function automatic mec_pkg::mec_out_t contract_energy(int unsigned n);
    longint            acc;
    logic              sat;
    int unsigned       base;
    mec_pkg::mec_out_t res;
    acc = 0;
    sat = 1'b0;
    for (int unsigned p = 0; p < n; p++)
      for (int unsigned q = 0; q < n; q++)
        for (int unsigned r = 0; r < n; r++)
          for (int unsigned s = 0; s < n; s++) begin
            base = (p * n + q) * n;
            acc  = mac_q24(acc, v_store[(base + r) * n + s], d_store[(base + s) * n + r], sat);
          end
    for (int unsigned p = 0; p < n * n; p++)
      acc = mac_q24(acc, h_store[p], r_store[p], sat);
    res.energy    = acc;
    res.saturated = sat;
    return res;
  endfunction

  function automatic void apply_request(mec_pkg::mec_in_t b);
    int unsigned n;
    int unsigned idx;
    int          val;
    n   = orbs_eff();
    idx = 32'(b.elem_index);
    val = b.elem_value;
    case (b.req_type)
      mec_pkg::REQ_LOAD_V: begin
        if (idx < n * n * n * n) begin
          v_store[idx] = val;
          if (idx == v_prefix) v_prefix++;
        end
      end
      mec_pkg::REQ_LOAD_D: begin
        if (idx < n * n * n * n) begin
          d_store[idx] = val;
          if (idx == d_prefix) d_prefix++;
        end
      end
      mec_pkg::REQ_LOAD_H: begin
        if (idx < n * n) begin
          h_store[idx] = val;
          if (idx == h_prefix) h_prefix++;
        end
      end
      mec_pkg::REQ_LOAD_R: begin
        if (idx < n * n) begin
          r_store[idx] = val;
          if (idx == r_prefix) r_prefix++;
        end
      end
      mec_pkg::REQ_COMPUTE: pending_energy.push_back(contract_energy(n));
      default: ;
    endcase
  endfunction

  function automatic mec_pkg::mec_in_t make_beat(logic [2:0] kind, int unsigned idx, int val);
    mec_pkg::mec_in_t b;
    b.req_type   = kind;
    b.elem_index = idx[15:0];
    b.elem_value = val;
    return b;
  endfunction

  function automatic int rand_q24();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return int'($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
    endcase
  endfunction

  task automatic send_beat(input mec_pkg::mec_in_t beat);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_request(beat);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_energy.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_orbs(input logic [4:0] value);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    orb_reg = value;
    cfg_valid <= 1'b0;
  endtask

  // write every entry from each store's written prefix up to the current extents
  task automatic fill_stores();
    int unsigned n;
    n = orbs_eff();
    for (int unsigned i = v_prefix; i < n * n * n * n; i++)
      send_beat(make_beat(mec_pkg::REQ_LOAD_V, i, rand_q24()));
    for (int unsigned i = d_prefix; i < n * n * n * n; i++)
      send_beat(make_beat(mec_pkg::REQ_LOAD_D, i, rand_q24()));
    for (int unsigned i = h_prefix; i < n * n; i++)
      send_beat(make_beat(mec_pkg::REQ_LOAD_H, i, rand_q24()));
    for (int unsigned i = r_prefix; i < n * n; i++)
      send_beat(make_beat(mec_pkg::REQ_LOAD_R, i, rand_q24()));
  endtask

  task automatic rand_request();
    int unsigned n;
    int unsigned lim;
    int unsigned sel;
    logic [2:0]  kind;
    n    = orbs_eff();
    sel  = $urandom_range(0, 99);
    kind = 3'($urandom_range(0, 3));
    lim  = (kind == mec_pkg::REQ_LOAD_V || kind == mec_pkg::REQ_LOAD_D) ?
           n * n * n * n : n * n;
    if (sel < 15 && v_prefix >= n * n * n * n && d_prefix >= n * n * n * n &&
        h_prefix >= n * n && r_prefix >= n * n)
      send_beat(make_beat(mec_pkg::REQ_COMPUTE, $urandom, $urandom));
    else if (sel < 70)
      send_beat(make_beat(kind, $urandom_range(0, lim - 1), rand_q24()));
    else if (sel < 79)
      send_beat(make_beat(kind, lim, rand_q24()));
    else if (sel < 88)
      send_beat(make_beat(kind, $urandom, $urandom));
    else
      send_beat(make_beat(3'($urandom_range(5, 7)), $urandom, $urandom));
  endtask

  task automatic test_single_orbital();
    send_beat(make_beat(mec_pkg::REQ_LOAD_V, 0, 32'h7FFF_FFFF));
    send_beat(make_beat(mec_pkg::REQ_LOAD_D, 0, 32'h7FFF_FFFF));
    send_beat(make_beat(mec_pkg::REQ_LOAD_H, 0, 32'h8000_0000));
    send_beat(make_beat(mec_pkg::REQ_LOAD_R, 0, 32'h8000_0000));
    send_beat(make_beat(mec_pkg::REQ_COMPUTE, 32'h0000_FFFF, 32'hFFFF_FFFF));
    // out of range loads and unknown requests leave the result unchanged
    send_beat(make_beat(mec_pkg::REQ_LOAD_V, 1, 32'h1234_5678));
    send_beat(make_beat(mec_pkg::REQ_LOAD_D, 32'h0000_FFFF, 32'h8000_0000));
    send_beat(make_beat(mec_pkg::REQ_LOAD_H, 1, 32'h7FFF_FFFF));
    send_beat(make_beat(mec_pkg::REQ_LOAD_R, 32'h0000_FFFF, 32'h0000_0001));
    send_beat(make_beat(3'd5, 32'h0000_FFFF, 32'hFFFF_FFFF));
    send_beat(make_beat(3'd6, 32'h0000_0000, 32'h0000_0000));
    send_beat(make_beat(3'd7, 32'h0000_FFFF, 32'h7FFF_FFFF));
    send_beat(make_beat(mec_pkg::REQ_COMPUTE, 0, 0));
    // negative product floors towards minus infinity
    send_beat(make_beat(mec_pkg::REQ_LOAD_V, 0, 32'hFFFF_FFFF));
    send_beat(make_beat(mec_pkg::REQ_LOAD_D, 0, 32'h0000_0001));
    send_beat(make_beat(mec_pkg::REQ_LOAD_H, 0, 0));
    send_beat(make_beat(mec_pkg::REQ_LOAD_R, 0, 0));
    send_beat(make_beat(mec_pkg::REQ_COMPUTE, 32'h0000_8000, 32'h8000_0000));
    send_beat(make_beat(mec_pkg::REQ_LOAD_V, 0, 32'h8000_0000));
    send_beat(make_beat(mec_pkg::REQ_LOAD_D, 0, 32'h7FFF_FFFF));
    send_beat(make_beat(mec_pkg::REQ_COMPUTE, 32'h0000_5555, 32'h5555_5555));
  endtask

  task automatic test_orbital_clamp();
    write_orbs(5'd0);
    send_beat(make_beat(mec_pkg::REQ_LOAD_V, 1, rand_q24()));
    send_beat(make_beat(mec_pkg::REQ_LOAD_H, 1, rand_q24()));
    send_beat(make_beat(mec_pkg::REQ_COMPUTE, 0, 0));
    write_orbs(5'd2);
    fill_stores();
    send_beat(make_beat(mec_pkg::REQ_LOAD_D, 16, rand_q24()));
    send_beat(make_beat(mec_pkg::REQ_LOAD_R, 4, rand_q24()));
    send_beat(make_beat(mec_pkg::REQ_COMPUTE, 0, 0));
    write_orbs(5'd3);
    fill_stores();
    send_beat(make_beat(mec_pkg::REQ_COMPUTE, 0, 0));
  endtask

  // receiver holds off while computes keep coming, so the block backs up its input
  task automatic test_output_hold_off();
    write_orbs(5'd1);
    hold_req_seq <= hold_req_seq + 1;
    repeat (12) begin
      send_beat(make_beat(mec_pkg::REQ_COMPUTE, $urandom, $urandom));
      send_beat(make_beat(3'($urandom_range(0, 3)), 0, rand_q24()));
    end
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 6; phase++) begin
      write_orbs(5'($urandom_range(0, 3)));
      gaps_on = (phase % 3 != 2);
      fill_stores();
      repeat (110) rand_request();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_full_size();
    write_orbs(5'd31);
    send_beat(make_beat(mec_pkg::REQ_LOAD_V, 32'h0000_FFFF, rand_q24()));
    send_beat(make_beat(mec_pkg::REQ_LOAD_D, 32'h0000_FFFF, rand_q24()));
    send_beat(make_beat(mec_pkg::REQ_LOAD_H, 255, rand_q24()));
    send_beat(make_beat(mec_pkg::REQ_LOAD_R, 255, rand_q24()));
    write_orbs(5'd16);
    repeat (8) send_beat(make_beat(3'($urandom_range(0, 3)), $urandom, rand_q24()));
    write_orbs(5'd3);
    fill_stores();
    send_beat(make_beat(mec_pkg::REQ_COMPUTE, 0, 0));
  endtask

  // result checking and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_energy.size() == 0) begin
        $error("out beat with no energy pending: energy %0d", out_data.energy);
        fail_count++;
      end else begin
        exp_beat = pending_energy.pop_front();
        if (out_data.energy !== exp_beat.energy) begin
          $error("energy: expected %0d, got %0d", exp_beat.energy, out_data.energy);
          fail_count++;
        end
        if (out_data.saturated !== exp_beat.saturated) begin
          $error("saturated: expected %0b, got %0b", exp_beat.saturated, out_data.saturated);
          fail_count++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req_seq != hold_seen) begin
      hold_seen = hold_req_seq;
      hold_left = HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (ready_run == 0) begin
        ready_lvl = ($urandom_range(0, 3) != 0);
        ready_run = ready_lvl ? $urandom_range(1, 40) : $urandom_range(1, 12);
      end
      ready_run--;
      out_ready <= ready_lvl;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_orbital();
    test_orbital_clamp();
    test_output_hold_off();
    test_random_mix();
    test_full_size();
    settle_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
